>>> sv/mfau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mfau_pkg;

   localparam int IdW        = 11;
   localparam int AngleW     = 13;
   localparam int SpeedW     = 16;
   localparam int StepW      = 14;
   localparam int TotalW     = 32;
   localparam int MaskW      = 8;
   localparam int IndexW     = 3;
   localparam int ReqDataW   = 48;
   localparam int RspDataW   = 80;

   // one extra bit over the angle for the raw difference, one for the
   // difference shifted by a full turn
   localparam int CalcW         = AngleW + 2;
   localparam int CountsPerTurn = 8192;

   localparam logic [6:0]       IdPrefix  = 7'h20;
   localparam logic [MaskW-1:0] MaskReset = 8'hFF;

   typedef struct packed {
      logic [TotalW-1:0] angle_total;
      logic [StepW-1:0]  angle_step;
      logic [SpeedW-1:0] speed_now;
      logic [AngleW-1:0] angle_now;
      logic [IndexW-1:0] motor_index;
   } rsp_word_type;

endpackage

`default_nettype wire

>>> sv/motor_feedback_angle_unwrap.sv
`timescale 1ns / 1ps
`default_nettype none

// Multi-turn angle unwrap for motor feedback frames. Each input word is one
// received CAN frame; standard frames with identifiers 0x201 up to
// 0x200+MOTOR_COUNT give one output word, all others are dropped silently.
// The block takes one frame per clock: a frame is held in the input register
// and its result is loaded into the output register, where the per-motor
// angle and sum registers are read and written in the same cycle, so
// consecutive frames for the same motor need no stall. Throughput drops only
// while the output word is held by rsp_tready. The user must write the enable
// mask through csr_we / csr_wdata only while no frame is in flight; the block
// leaves this check to the user. A cleared bit freezes that motor's sum and
// reports a zero step. Angle and sum registers are cleared by reset.
module motor_feedback_angle_unwrap
   import mfau_pkg::*;
#(
   parameter int MOTOR_COUNT = 8
) (
   input  wire                  clock,
   input  wire                  reset,

   input  wire                  csr_we,
   input  wire [MaskW-1:0]      csr_wdata,

   input  wire                  req_tvalid,
   output logic                 req_tready,
   // frame_id, angle_high_byte, angle_low_byte, speed_high_byte, speed_low_byte
   input  wire [ReqDataW-1:0]   req_tdata,
   // is_standard
   input  wire [0:0]            req_tuser,

   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   // motor_index, angle_now, speed_now, angle_step, angle_total
   output logic [RspDataW-1:0]  rsp_tdata
);

   localparam int IdxW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

   logic [MaskW-1:0]         mask_ff;
   logic [AngleW-1:0]        prev_angle_ff [MOTOR_COUNT];
   logic [TotalW-1:0]        total_ff      [MOTOR_COUNT];

   logic                     s1_valid_ff, s1_valid_in;
   logic [IdxW-1:0]          s1_idx_ff;
   logic [AngleW-1:0]        s1_angle_ff;
   logic [SpeedW-1:0]        s1_speed_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_word_type             rsp_word_ff, rsp_word_in;

   logic [IdW-1:0]           req_id;
   logic [3:0]               req_nib;
   logic [3:0]               req_idx;
   logic                     req_accept;
   logic                     req_keep;
   logic                     advance;

   logic [AngleW-1:0]        prev_angle;
   logic [TotalW-1:0]        total_old;
   logic                     motor_en;
   logic signed [CalcW-1:0]  d1, d2, step;
   logic [CalcW-1:0]         a1, a2;
   logic [TotalW-1:0]        total_new;

   assign req_id  = req_tdata[IdW-1:0];
   assign req_nib = req_id[3:0];
   assign req_idx = req_nib - 4'd1;
   assign req_keep = req_tuser[0] && (req_id[10:4] == IdPrefix) && (req_nib != 4'd0)
                     && (req_nib <= 4'(MOTOR_COUNT));

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      if (req_accept) begin
         s1_valid_in = req_keep;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   assign prev_angle = prev_angle_ff[s1_idx_ff];
   assign total_old  = total_ff[s1_idx_ff];
   assign motor_en   = mask_ff[IndexW'(s1_idx_ff)];

   always_comb begin
      d1 = signed'({2'b00, s1_angle_ff}) - signed'({2'b00, prev_angle});
      if (s1_angle_ff > prev_angle) begin
         d2 = d1 - CalcW'(CountsPerTurn);
      end else begin
         d2 = d1 + CalcW'(CountsPerTurn);
      end
      a1 = d1[CalcW-1] ? unsigned'(-d1) : unsigned'(d1);
      a2 = d2[CalcW-1] ? unsigned'(-d2) : unsigned'(d2);
      if (!motor_en) begin
         step = '0;
      end else if (a1 < a2) begin
         step = d1;
      end else begin
         step = d2;
      end
      total_new = total_old + {{(TotalW-CalcW){step[CalcW-1]}}, step};
   end

   always_comb begin
      rsp_word_in.motor_index = IndexW'(s1_idx_ff);
      rsp_word_in.angle_now   = s1_angle_ff;
      rsp_word_in.speed_now   = s1_speed_ff;
      rsp_word_in.angle_step  = step[StepW-1:0];
      rsp_word_in.angle_total = total_new;
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= MaskReset;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int m = 0; m < MOTOR_COUNT; m++) begin
            prev_angle_ff[m] <= '0;
            total_ff[m]      <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            mask_ff <= csr_wdata;
         end
         if (advance && motor_en) begin
            prev_angle_ff[s1_idx_ff] <= s1_angle_ff;
            total_ff[s1_idx_ff]      <= total_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_idx_ff   <= req_idx[IdxW-1:0];
         s1_angle_ff <= {req_tdata[15:11], req_tdata[26:19]};
         s1_speed_ff <= {req_tdata[34:27], req_tdata[42:35]};
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RspDataW-$bits(rsp_word_type))'(0), rsp_word_ff};

endmodule

`default_nettype wire

>>> sv/mfau_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mfau_checker
   import mfau_pkg::*;
#(
   parameter int MOTOR_COUNT = 8
) (
   input wire                 clock,
   input wire                 reset,
   input wire                 rsp_tvalid,
   input wire                 rsp_tready,
   input wire [RspDataW-1:0]  rsp_tdata
);

   rsp_word_type rsp_word;
   logic signed [StepW-1:0] rsp_step;

   assign rsp_word = rsp_tdata[$bits(rsp_word_type)-1:0];
   assign rsp_step = signed'(rsp_word.angle_step);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output word valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled output word changed");

   a_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_word.motor_index) < MOTOR_COUNT))
      else $error("motor index out of range");

   a_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (int'(rsp_step) >= -4096) && (int'(rsp_step) <= 4096))
      else $error("angle step beyond half a turn");

endmodule

bind motor_feedback_angle_unwrap mfau_checker #(
   .MOTOR_COUNT (MOTOR_COUNT)
) u_mfau_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

>>> dv/tb_motor_feedback_angle_unwrap.sv
`timescale 1ns / 1ps

module tb_motor_feedback_angle_unwrap;
   import mfau_pkg::*;

   localparam int MotorCount = 8;
   localparam int CycleLimit = 400000;
   localparam int SegItems   = 110;

   typedef struct {
      logic [IdW-1:0] id;
      logic           is_std;
      logic [7:0]     angle_hi;
      logic [7:0]     angle_lo;
      logic [7:0]     speed_hi;
      logic [7:0]     speed_lo;
   } can_frame_t;

   class unwrap_scoreboard;
      logic [MaskW-1:0]  enable_mask;
      logic [AngleW-1:0] last_angle[MotorCount];
      logic [TotalW-1:0] turn_sum[MotorCount];
      rsp_word_type      pending[$];
      int                mismatches;

      function new();
         enable_mask = MaskReset;
         mismatches  = 0;
         foreach (last_angle[i]) begin
            last_angle[i] = '0;
            turn_sum[i]   = '0;
         end
      endfunction

      function void note_frame(can_frame_t f);
         logic [AngleW-1:0] angle;
         logic [IndexW-1:0] m;
         int                d1;
         int                d2;
         int                step;
         rsp_word_type      w;
         if (!f.is_std || f.id[10:4] != IdPrefix || f.id[3:0] == 4'd0 ||
             f.id[3:0] > MotorCount)
            return;
         m     = IndexW'(f.id[3:0] - 4'd1);
         angle = {f.angle_hi[4:0], f.angle_lo};
         step  = 0;
         if (enable_mask[m]) begin
            d1 = int'(angle) - int'(last_angle[m]);
            if (angle > last_angle[m]) d2 = d1 - CountsPerTurn;
            else d2 = d1 + CountsPerTurn;
            // half-turn tie goes to the wrapped step
            step          = ((d1 < 0 ? -d1 : d1) < (d2 < 0 ? -d2 : d2)) ? d1 : d2;
            last_angle[m] = angle;
            turn_sum[m]   = turn_sum[m] + step;
         end
         w.motor_index = m;
         w.angle_now   = angle;
         w.speed_now   = {f.speed_hi, f.speed_lo};
         w.angle_step  = step[StepW-1:0];
         w.angle_total = turn_sum[m];
         pending.push_back(w);
      endfunction

      function void check_word(logic [RspDataW-1:0] data);
         rsp_word_type got;
         rsp_word_type exp_w;
         got = data[$bits(rsp_word_type)-1:0];
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected word idx %0d angle %0d total %0d",
                        got.motor_index, got.angle_now, $signed(got.angle_total));
            return;
         end
         exp_w = pending.pop_front();
         if (got.motor_index != exp_w.motor_index || got.angle_now != exp_w.angle_now ||
             got.speed_now != exp_w.speed_now || got.angle_step != exp_w.angle_step ||
             got.angle_total != exp_w.angle_total) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: exp idx %0d angle %0d speed %0d step %0d total %0d",
                        exp_w.motor_index, exp_w.angle_now, $signed(exp_w.speed_now),
                        $signed(exp_w.angle_step), $signed(exp_w.angle_total));
               $display("       got idx %0d angle %0d speed %0d step %0d total %0d",
                        got.motor_index, got.angle_now, $signed(got.speed_now),
                        $signed(got.angle_step), $signed(got.angle_total));
            end
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we = 1'b0;
   logic [MaskW-1:0]    csr_wdata = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic [0:0]          req_tuser = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;

   int                  send_idle_pct = 35;
   int                  recv_idle_pct = 69;
   int                  cycles = 0;
   unwrap_scoreboard    sb;

   motor_feedback_angle_unwrap #(
      .MOTOR_COUNT(MotorCount)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic can_frame_t mk(logic [IdW-1:0] id, logic is_std, logic [7:0] ah,
                                     logic [7:0] al, logic [7:0] sh, logic [7:0] sl);
      can_frame_t f;
      f.id       = id;
      f.is_std   = is_std;
      f.angle_hi = ah;
      f.angle_lo = al;
      f.speed_hi = sh;
      f.speed_lo = sl;
      return f;
   endfunction

   function automatic can_frame_t rand_frame();
      can_frame_t  f;
      int          m;
      int          a;
      logic [15:0] a16;
      f = mk(IdW'($urandom), 1'b1, 8'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom));
      if ($urandom_range(99) < 12) begin
         case ($urandom_range(3))
            0: f.is_std = 1'($urandom);
            1: f.id = 11'h200 | IdW'($urandom_range(9, 16) & 15);
            2: begin
               f.id     = 11'h200 + IdW'($urandom_range(1, MotorCount));
               f.is_std = 1'b0;
            end
            default: ;
         endcase
         return f;
      end
      m    = $urandom_range(MotorCount - 1);
      f.id = 11'h201 + IdW'(m);
      a    = int'(sb.last_angle[m]);
      case ($urandom_range(9))
         0, 1, 2, 3: a = a + $urandom_range(400) - 200;
         4, 5:       a = $urandom;
         6:          a = a + 4095 + $urandom_range(2);
         7:          a = a - 4095 - $urandom_range(2);
         8:          ;
         default:    a = a + $urandom_range(8191);
      endcase
      a16        = {3'($urandom), a[12:0]};
      f.angle_hi = a16[15:8];
      f.angle_lo = a16[7:0];
      return f;
   endfunction

   task automatic send_frame(can_frame_t f);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, f.speed_lo, f.speed_hi, f.angle_lo, f.angle_hi, f.id};
      req_tuser  <= f.is_std;
      do @(posedge clock); while (!req_tready);
      sb.note_frame(f);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      // dropped frames may still sit in the pipe
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mask(logic [MaskW-1:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we         <= 1'b0;
      sb.enable_mask = v;
   endtask

   initial begin
      can_frame_t directed[$];
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // equal angles, half-turn ties both ways, ring edges, masked angle bits
      directed.push_back(mk(11'h201, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00));
      directed.push_back(mk(11'h201, 1'b1, 8'h10, 8'h00, 8'h12, 8'h34));
      directed.push_back(mk(11'h201, 1'b1, 8'h00, 8'h00, 8'h80, 8'h00));
      directed.push_back(mk(11'h208, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      directed.push_back(mk(11'h208, 1'b1, 8'hE0, 8'h00, 8'h7F, 8'hFF));
      directed.push_back(mk(11'h202, 1'b1, 8'h0F, 8'hFF, 8'h00, 8'h01));
      directed.push_back(mk(11'h202, 1'b1, 8'h1F, 8'hFF, 8'hFF, 8'hFE));
      directed.push_back(mk(11'h203, 1'b1, 8'h10, 8'h01, 8'h55, 8'hAA));
      directed.push_back(mk(11'h204, 1'b1, 8'h7F, 8'hFF, 8'h80, 8'h00));
      directed.push_back(mk(11'h205, 1'b1, 8'hA5, 8'h5A, 8'hAA, 8'h55));
      directed.push_back(mk(11'h206, 1'b1, 8'h01, 8'h00, 8'h00, 8'h00));
      directed.push_back(mk(11'h207, 1'b1, 8'h0E, 8'hFF, 8'h33, 8'hCC));
      // rejected frames
      directed.push_back(mk(11'h200, 1'b1, 8'h01, 8'h02, 8'h03, 8'h04));
      directed.push_back(mk(11'h209, 1'b1, 8'h01, 8'h02, 8'h03, 8'h04));
      directed.push_back(mk(11'h20F, 1'b1, 8'h01, 8'h02, 8'h03, 8'h04));
      directed.push_back(mk(11'h201, 1'b0, 8'h01, 8'h02, 8'h03, 8'h04));
      directed.push_back(mk(11'h7FF, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      directed.push_back(mk(11'h000, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00));
      directed.push_back(mk(11'h301, 1'b1, 8'h01, 8'h02, 8'h03, 8'h04));
      directed.push_back(mk(11'h211, 1'b1, 8'h01, 8'h02, 8'h03, 8'h04));
      foreach (directed[i]) send_frame(directed[i]);

      // all motors disabled: step zero, sum frozen
      write_mask(8'h00);
      send_frame(mk(11'h201, 1'b1, 8'h08, 8'h00, 8'h01, 8'h00));
      send_frame(mk(11'h208, 1'b1, 8'h05, 8'h00, 8'hFF, 8'h00));

      for (int seg = 0; seg < 6; seg++) begin
         case (seg / 2)
            0: begin
               send_idle_pct = 35;
               recv_idle_pct = 69;
            end
            1: begin
               send_idle_pct = 69;
               recv_idle_pct = 35;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (seg)
            0, 4:    write_mask(8'hFF);
            3:       write_mask(8'h00);
            default: write_mask(MaskW'($urandom));
         endcase
         for (int i = 0; i < SegItems; i++) send_frame(rand_frame());
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.pending.size() != 0)
         $display("ERROR: %0d expected words never arrived", sb.pending.size());
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
